>>> hdl/circular_flash_log_writer_core_defines.svh
// Assertion macros for the log writer core.
// Both expect clk and rst to be visible where they are used.
`ifndef CIRCULAR_FLASH_LOG_WRITER_CORE_DEFINES_SVH
`define CIRCULAR_FLASH_LOG_WRITER_CORE_DEFINES_SVH

// Same-cycle implication.
`define CFLW_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define CFLW_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/cflw_pkg.sv
`default_nettype none

package cflw_pkg;

  localparam int HEADER_BYTES = 4;
  localparam int MAX_STEPS = 6;

  typedef enum logic [2:0] {
    KIND_ERASE    = 3'd0,
    KIND_HEADER   = 3'd1,
    KIND_RECORD   = 3'd2,
    KIND_DISABLED = 3'd3,
    KIND_OVERSIZE = 3'd4
  } cmd_kind_t;

  typedef enum logic [1:0] {
    REG_REGION_START = 2'd0,
    REG_REGION_END   = 2'd1,
    REG_LOG_DISABLED = 2'd2
  } reg_index_t;

  typedef enum logic [2:0] {
    STEP_ERASE_A  = 3'd0,
    STEP_HDR_A    = 3'd1,
    STEP_SEG1     = 3'd2,
    STEP_ERASE_B  = 3'd3,
    STEP_HDR_B    = 3'd4,
    STEP_SEG2     = 3'd5,
    STEP_DISABLED = 3'd6,
    STEP_OVERSIZE = 3'd7
  } step_t;

  typedef struct packed {
    logic [31:0] region_start;
    logic [31:0] region_end;
    logic        log_disabled;
  } cfg_t;

  typedef struct packed {
    step_t [MAX_STEPS-1:0] steps;
    logic [2:0]            nsteps;
    logic [31:0]           addr_a;
    logic [31:0]           addr_seg1;
    logic [31:0]           addr_b;
    logic [31:0]           addr_seg2;
    logic [10:0]           cnt1;
    logic [10:0]           cnt2;
    logic [9:0]            roff;
    logic [7:0]            serial_a;
    logic [7:0]            serial_b;
    logic [10:0]           first_b;
    logic [31:0]           oldest_a;
    logic [31:0]           oldest_b;
  } plan_t;

endpackage

`default_nettype wire

>>> hdl/cflw_rec_if.sv
`default_nettype none

interface cflw_rec_if;
  logic       valid;
  logic       ready;
  logic [9:0] record_length;

  modport source (output valid, output record_length, input ready);
  modport sink (input valid, input record_length, output ready);
endinterface

`default_nettype wire

>>> hdl/cflw_cmd_if.sv
`default_nettype none

interface cflw_cmd_if;
  logic        valid;
  logic        ready;
  logic [2:0]  command_kind;
  logic [31:0] flash_address;
  logic [10:0] byte_count;
  logic [9:0]  record_offset;
  logic [7:0]  header_serial;
  logic [10:0] header_first_record;
  logic [31:0] oldest_page;
  logic        last_command;

  modport source (
    output valid, output command_kind, output flash_address, output byte_count,
    output record_offset, output header_serial, output header_first_record,
    output oldest_page, output last_command, input ready
  );
  modport sink (
    input valid, input command_kind, input flash_address, input byte_count,
    input record_offset, input header_serial, input header_first_record,
    input oldest_page, input last_command, output ready
  );
endinterface

`default_nettype wire

>>> hdl/cflw_planner.sv
`default_nettype none

module cflw_planner #(
  parameter int PAGE_BYTES = 1024
) (
  input  logic            clk,
  input  logic            rst,
  input  cflw_pkg::cfg_t  cfg,
  cflw_rec_if.sink        rec_in,
  input  logic            plan_ready,
  output logic            plan_valid,
  output cflw_pkg::plan_t plan
);
  import cflw_pkg::*;

  localparam int PB = $clog2(PAGE_BYTES);
  localparam int PN = 32 - PB;
  localparam int SW = ((PB > 10) ? PB : 10) + 1;

  logic          in_full;
  logic [9:0]    len_q;
  logic          page_open;
  logic [7:0]    serial_count;
  logic [PN-1:0] oldest_page;
  logic [PN-1:0] newest_page;
  logic [PB-1:0] write_offset;

  logic          take;
  logic          oversize;
  logic          reject;
  logic [PN-1:0] lo_pn;
  logic [PN-1:0] hi_pn;
  logic [PN-1:0] pe;
  logic [PN-1:0] oa;
  logic [PN-1:0] n_inc;
  logic [PN-1:0] n_pg;
  logic [PN-1:0] o_inc;
  logic [PN-1:0] o_next;
  logic [PN-1:0] ob;
  logic [PB-1:0] off_e;
  logic [PB-1:0] offset_next;
  logic [7:0]    se;
  logic [SW-1:0] len_w;
  logic [SW-1:0] left;
  logic [SW-1:0] sum;
  logic [SW-1:0] cnt2;
  logic          split;
  logic          post;
  logic          open_b;
  logic [2:0]    k;

  assign take          = in_full && plan_ready;
  assign plan_valid    = in_full;
  assign rec_in.ready  = !in_full || plan_ready;

  assign lo_pn = cfg.region_start[31:PB];
  assign hi_pn = cfg.region_end[31:PB];
  assign pe    = page_open ? newest_page : lo_pn;
  assign oa    = page_open ? oldest_page : lo_pn;
  assign off_e = page_open ? write_offset : PB'(HEADER_BYTES);
  assign se    = page_open ? serial_count : serial_count + 8'd1;

  assign len_w    = SW'(len_q);
  assign oversize = (len_q == 10'd0) || (len_w > SW'(PAGE_BYTES - HEADER_BYTES));
  assign reject   = cfg.log_disabled || oversize;
  assign left     = SW'(PAGE_BYTES) - SW'(off_e);
  assign sum      = SW'(off_e) + len_w;
  assign split    = len_w > left;
  assign post     = !split && (sum == SW'(PAGE_BYTES));
  assign open_b   = split || post;
  assign cnt2     = len_w - left;

  // next page after the current one, wrapping at the region end
  assign n_inc  = pe + PN'(1);
  assign n_pg   = (n_inc >= hi_pn) ? lo_pn : n_inc;
  assign o_inc  = oa + PN'(1);
  assign o_next = (o_inc >= hi_pn) ? lo_pn : o_inc;
  assign ob     = (n_pg == oa) ? o_next : oa;

  always_comb begin
    if (split) begin
      offset_next = PB'(HEADER_BYTES) + PB'(cnt2);
    end else if (post) begin
      offset_next = PB'(HEADER_BYTES);
    end else begin
      offset_next = PB'(sum);
    end
  end

  always_comb begin
    plan = '0;
    k    = 3'd0;
    if (cfg.log_disabled) begin
      plan.steps[0] = STEP_DISABLED;
      k = 3'd1;
    end else if (oversize) begin
      plan.steps[0] = STEP_OVERSIZE;
      k = 3'd1;
    end else begin
      if (!page_open) begin
        plan.steps[k] = STEP_ERASE_A;
        k = k + 3'd1;
        plan.steps[k] = STEP_HDR_A;
        k = k + 3'd1;
      end
      plan.steps[k] = STEP_SEG1;
      k = k + 3'd1;
      if (open_b) begin
        plan.steps[k] = STEP_ERASE_B;
        k = k + 3'd1;
        plan.steps[k] = STEP_HDR_B;
        k = k + 3'd1;
      end
      if (split) begin
        plan.steps[k] = STEP_SEG2;
        k = k + 3'd1;
      end
    end
    plan.nsteps    = k;
    plan.addr_a    = {pe, {PB{1'b0}}};
    plan.addr_seg1 = {pe, off_e};
    plan.addr_b    = {n_pg, {PB{1'b0}}};
    plan.addr_seg2 = {n_pg, PB'(HEADER_BYTES)};
    plan.cnt1      = split ? 11'(left) : 11'(len_q);
    plan.cnt2      = 11'(cnt2);
    plan.roff      = 10'(left);
    plan.serial_a  = serial_count + 8'd1;
    plan.serial_b  = se + 8'd1;
    plan.first_b   = split ? 11'(HEADER_BYTES) + 11'(cnt2) : 11'(HEADER_BYTES);
    plan.oldest_a  = {(reject ? oldest_page : oa), {PB{1'b0}}};
    plan.oldest_b  = {ob, {PB{1'b0}}};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full      <= 1'b0;
      page_open    <= 1'b0;
      serial_count <= '0;
      oldest_page  <= '0;
      newest_page  <= '0;
      write_offset <= '0;
    end else begin
      if (rec_in.valid && rec_in.ready) begin
        in_full <= 1'b1;
      end else if (take) begin
        in_full <= 1'b0;
      end
      if (take && !reject) begin
        page_open    <= 1'b1;
        serial_count <= open_b ? se + 8'd1 : se;
        newest_page  <= open_b ? n_pg : pe;
        oldest_page  <= open_b ? ob : oa;
        write_offset <= offset_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rec_in.valid && rec_in.ready) begin
      len_q <= rec_in.record_length;
    end
  end

endmodule

`default_nettype wire

>>> hdl/cflw_emitter.sv
`default_nettype none

module cflw_emitter (
  input  logic            clk,
  input  logic            rst,
  input  logic            plan_valid,
  input  cflw_pkg::plan_t plan,
  output logic            plan_ready,
  cflw_cmd_if.source      cmd_out
);
  import cflw_pkg::*;

  logic       busy;
  logic [2:0] idx;
  plan_t      cur;
  logic       last;
  logic       load;

  assign last       = idx == (cur.nsteps - 3'd1);
  assign plan_ready = !busy || (cmd_out.ready && last);
  assign load       = plan_valid && plan_ready;

  assign cmd_out.valid        = busy;
  assign cmd_out.last_command = last;

  always_comb begin
    cmd_out.command_kind        = KIND_ERASE;
    cmd_out.flash_address       = '0;
    cmd_out.byte_count          = '0;
    cmd_out.record_offset       = '0;
    cmd_out.header_serial       = '0;
    cmd_out.header_first_record = '0;
    cmd_out.oldest_page         = cur.oldest_a;
    unique case (cur.steps[idx])
      STEP_ERASE_A: begin
        cmd_out.flash_address = cur.addr_a;
      end
      STEP_HDR_A: begin
        cmd_out.command_kind        = KIND_HEADER;
        cmd_out.flash_address       = cur.addr_a;
        cmd_out.header_serial       = cur.serial_a;
        cmd_out.header_first_record = 11'(HEADER_BYTES);
      end
      STEP_SEG1: begin
        cmd_out.command_kind  = KIND_RECORD;
        cmd_out.flash_address = cur.addr_seg1;
        cmd_out.byte_count    = cur.cnt1;
      end
      STEP_ERASE_B: begin
        cmd_out.flash_address = cur.addr_b;
        cmd_out.oldest_page   = cur.oldest_b;
      end
      STEP_HDR_B: begin
        cmd_out.command_kind        = KIND_HEADER;
        cmd_out.flash_address       = cur.addr_b;
        cmd_out.header_serial       = cur.serial_b;
        cmd_out.header_first_record = cur.first_b;
        cmd_out.oldest_page         = cur.oldest_b;
      end
      STEP_SEG2: begin
        cmd_out.command_kind  = KIND_RECORD;
        cmd_out.flash_address = cur.addr_seg2;
        cmd_out.byte_count    = cur.cnt2;
        cmd_out.record_offset = cur.roff;
        cmd_out.oldest_page   = cur.oldest_b;
      end
      STEP_DISABLED: begin
        cmd_out.command_kind = KIND_DISABLED;
      end
      STEP_OVERSIZE: begin
        cmd_out.command_kind = KIND_OVERSIZE;
      end
      default: begin
        cmd_out.command_kind = KIND_ERASE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= '0;
    end else if (load) begin
      busy <= 1'b1;
      idx  <= '0;
    end else if (busy && cmd_out.ready) begin
      if (last) begin
        busy <= 1'b0;
      end else begin
        idx <= idx + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      cur <= plan;
    end
  end

endmodule

`default_nettype wire

>>> hdl/circular_flash_log_writer_core.sv
`default_nettype none
// Channel   Dir  Payload                                    Request
// rec_in    in   record_length                              one append
// cmd_out   out  command_kind .. oldest_page, last_command  one flash command
//
// An append issues one command per cycle while cmd_out is ready: 1 when rejected, 1, 3 or 4
// normally, up to 5 when it opens the log and fills its first page; the planner sets the count.
// The request is registered in the planner, then loaded into the emitter to issue commands.
// rst is synchronous: log state is cleared, registers return to their defaults.
// A stall on cmd_out holds the current command; one more request is buffered.

module circular_flash_log_writer_core #(
  parameter int PAGE_BYTES = 1024
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  cflw_rec_if.sink    rec_in,
  cflw_cmd_if.source  cmd_out
);
  import cflw_pkg::*;
`include "circular_flash_log_writer_core_defines.svh"

  cfg_t  cfg;
  plan_t plan;
  logic  plan_valid;
  logic  plan_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.region_start <= 32'd0;
      cfg.region_end   <= 32'd8192;
      cfg.log_disabled <= 1'b0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_REGION_START: cfg.region_start <= cfg_data;
        REG_REGION_END:   cfg.region_end   <= cfg_data;
        REG_LOG_DISABLED: cfg.log_disabled <= cfg_data[0];
        default: ;
      endcase
    end
  end

  cflw_planner #(
    .PAGE_BYTES (PAGE_BYTES)
  ) u_planner (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .rec_in     (rec_in),
    .plan_ready (plan_ready),
    .plan_valid (plan_valid),
    .plan       (plan)
  );

  cflw_emitter u_emitter (
    .clk        (clk),
    .rst        (rst),
    .plan_valid (plan_valid),
    .plan       (plan),
    .plan_ready (plan_ready),
    .cmd_out    (cmd_out)
  );

  `CFLW_ASSERT_NEXT(a_more_follow, cmd_out.valid && cmd_out.ready && !cmd_out.last_command, cmd_out.valid, "command sequence broken before its last command")
  `CFLW_ASSERT_NOW(a_reject_single, cmd_out.valid && (cmd_out.command_kind == KIND_DISABLED || cmd_out.command_kind == KIND_OVERSIZE), cmd_out.last_command, "rejected request issued more than one command")
  `CFLW_ASSERT_NOW(a_header_first, cmd_out.valid && cmd_out.command_kind == KIND_HEADER, cmd_out.header_first_record >= 11'(HEADER_BYTES), "page header points inside the header")
  `CFLW_ASSERT_NOW(a_hold_input, plan_valid && !plan_ready, !rec_in.ready, "request taken while the buffered one is still waiting")

endmodule

`default_nettype wire

>>> dv/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import cflw_pkg::*;

  localparam int PAGE_BYTES = 1024;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct packed {
    cmd_kind_t   kind;
    logic [31:0] addr;
    logic [10:0] count;
    logic [9:0]  roff;
    logic [7:0]  serial;
    logic [10:0] first;
    logic [31:0] oldest;
    logic        last;
  } flash_cmd_t;

  typedef struct packed {
    logic                  is_cfg;
    reg_index_t            idx;
    logic [31:0]           value;
    logic [1:0]            ngold;
    flash_cmd_t [2:0]      gold;
  } script_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_write;
  logic [1:0]  cfg_index;
  logic [31:0] cfg_data;

  cflw_rec_if rec();
  cflw_cmd_if cmd();

  circular_flash_log_writer_core #(
    .PAGE_BYTES(PAGE_BYTES)
  ) u_top (
    .clk(clk),
    .rst(rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .rec_in(rec),
    .cmd_out(cmd)
  );

  always #6 clk = ~clk;

  logic [31:0] cfg_start = 32'd0;
  logic [31:0] cfg_stop = 32'd8192;
  logic        cfg_off = 1'b0;
  logic [31:0] wp_q = 32'd0;
  logic        opened = 1'b0;
  logic [7:0]  serial_q = 8'd0;
  logic [31:0] oldest_q = 32'd0;

  flash_cmd_t  fresh_cmds[$];
  flash_cmd_t  expected_cmds[$];
  flash_cmd_t  seen;
  flash_cmd_t  due;
  int          mismatches = 0;
  int          cycles = 0;
  int          stall = 0;
  bit          calm = 1'b0;

  function automatic logic [31:0] page_of(logic [31:0] a);
    return a & ~32'(PAGE_BYTES - 1);
  endfunction

  function automatic flash_cmd_t make_cmd(cmd_kind_t k, logic [31:0] a, logic [10:0] n,
                                          logic [7:0] s, logic [10:0] f, logic last);
    flash_cmd_t c;
    c = '0;
    c.kind = k;
    c.addr = a;
    c.count = n;
    c.serial = s;
    c.first = f;
    c.last = last;
    return c;
  endfunction

  function automatic void issue(cmd_kind_t k, logic [31:0] a, logic [10:0] n, logic [9:0] ro,
                                logic [7:0] s, logic [10:0] f);
    flash_cmd_t c;
    c = make_cmd(k, a, n, s, f, 1'b0);
    c.roff = ro;
    c.oldest = opened ? oldest_q : 32'd0;
    fresh_cmds.push_back(c);
  endfunction

  function automatic logic [31:0] open_log_page(logic [31:0] a, logic [10:0] carry);
    logic [31:0] lo;
    logic [31:0] hi;
    lo = page_of(cfg_start);
    hi = page_of(cfg_stop);
    if (a >= hi) a = lo;
    serial_q = serial_q + 8'd1;
    if (!opened) begin
      oldest_q = a;
      opened = 1'b1;
    end else if (page_of(a) == page_of(oldest_q)) begin
      oldest_q = oldest_q + 32'(PAGE_BYTES);
      if (oldest_q >= hi) oldest_q = lo;
    end
    issue(KIND_ERASE, a, '0, '0, '0, '0);
    issue(KIND_HEADER, a, '0, '0, serial_q, carry + 11'(HEADER_BYTES));
    return a + 32'(HEADER_BYTES);
  endfunction

  function automatic void model_append(logic [9:0] len);
    logic [31:0] room;
    flash_cmd_t  tail;
    fresh_cmds.delete();
    if (cfg_off) begin
      issue(KIND_DISABLED, '0, '0, '0, '0, '0);
    end else if (len == 10'd0 || 32'(len) > 32'(PAGE_BYTES - HEADER_BYTES)) begin
      issue(KIND_OVERSIZE, '0, '0, '0, '0, '0);
    end else begin
      if (!opened) wp_q = open_log_page(page_of(cfg_start), '0);
      room = 32'(PAGE_BYTES) - (wp_q % 32'(PAGE_BYTES));
      if (32'(len) > room) begin
        issue(KIND_RECORD, wp_q, room[10:0], '0, '0, '0);
        wp_q = wp_q + room;
        wp_q = open_log_page(wp_q, 11'(len) - room[10:0]);
        issue(KIND_RECORD, wp_q, 11'(len) - room[10:0], room[9:0], '0, '0);
        wp_q = wp_q + 32'(len) - room;
      end else begin
        issue(KIND_RECORD, wp_q, 11'(len), '0, '0, '0);
        wp_q = wp_q + 32'(len);
      end
      if (wp_q % 32'(PAGE_BYTES) == 32'd0) wp_q = open_log_page(wp_q, '0);
    end
    tail = fresh_cmds.pop_back();
    tail.last = 1'b1;
    fresh_cmds.push_back(tail);
  endfunction

  function automatic int idle_gap();
    if (calm || $urandom_range(0, 9) < 6) return 0;
    if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [9:0] random_len();
    int pick;
    int room;
    pick = $urandom_range(0, 99);
    room = PAGE_BYTES - int'(wp_q % 32'(PAGE_BYTES));
    if (pick < 4) return ($urandom_range(0, 3) == 0) ? 10'd0 : 10'($urandom_range(1021, 1023));
    if (pick < 16) return (room <= PAGE_BYTES - HEADER_BYTES) ? 10'(room) : 10'd1020;
    if (pick < 36) return 10'($urandom_range(1, 16));
    if (pick < 60) return 10'($urandom_range(900, 1020));
    return 10'($urandom_range(1, 1020));
  endfunction

  function automatic script_row_t row_item(logic [9:0] len);
    script_row_t r;
    r = '0;
    r.value = 32'(len);
    return r;
  endfunction

  function automatic script_row_t row_reject(logic [9:0] len, cmd_kind_t k);
    script_row_t r;
    r = row_item(len);
    r.ngold = 2'd1;
    r.gold[0] = make_cmd(k, '0, '0, '0, '0, 1'b1);
    return r;
  endfunction

  function automatic script_row_t row_cfg(reg_index_t idx, logic [31:0] v);
    script_row_t r;
    r = '0;
    r.is_cfg = 1'b1;
    r.idx = idx;
    r.value = v;
    return r;
  endfunction

  task automatic write_reg(reg_index_t idx, logic [31:0] v);
    rec.valid <= 1'b0;
    while (expected_cmds.size() != 0) @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    @(posedge clk);
    case (idx)
      REG_REGION_START: cfg_start = v;
      REG_REGION_END:   cfg_stop = v;
      REG_LOG_DISABLED: cfg_off = v[0];
      default: ;
    endcase
    cfg_write <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_record(script_row_t r);
    int gap;
    gap = idle_gap();
    if (gap > 0) begin
      rec.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    rec.valid <= 1'b1;
    rec.record_length <= r.value[9:0];
    do @(posedge clk); while (!rec.ready);
    model_append(r.value[9:0]);
    if (r.ngold == 2'd0) begin
      foreach (fresh_cmds[i]) expected_cmds.push_back(fresh_cmds[i]);
    end else begin
      for (int i = 0; i < int'(r.ngold); i++) expected_cmds.push_back(r.gold[i]);
    end
  endtask

  task automatic report_miss(string what, flash_cmd_t want, flash_cmd_t got);
    mismatches++;
    if (mismatches <= 10)
      $display("%s exp/got: kind %0d/%0d addr %h/%h count %0d/%0d roff %0d/%0d serial %0d/%0d first %0d/%0d oldest %h/%h last %0d/%0d",
               what, want.kind, got.kind, want.addr, got.addr, want.count, got.count,
               want.roff, got.roff, want.serial, got.serial, want.first, got.first,
               want.oldest, got.oldest, want.last, got.last);
  endtask

  always @(posedge clk) begin
    if (!rst && cmd.valid && cmd.ready) begin
      seen.kind = cmd_kind_t'(cmd.command_kind);
      seen.addr = cmd.flash_address;
      seen.count = cmd.byte_count;
      seen.roff = cmd.record_offset;
      seen.serial = cmd.header_serial;
      seen.first = cmd.header_first_record;
      seen.oldest = cmd.oldest_page;
      seen.last = cmd.last_command;
      if (expected_cmds.size() == 0) begin
        report_miss("unexpected command", '0, seen);
      end else begin
        due = expected_cmds.pop_front();
        if (seen !== due) report_miss("command mismatch", due, seen);
      end
    end
  end

  always @(posedge clk) begin
    if (stall > 0) begin
      cmd.ready <= 1'b0;
      stall <= stall - 1;
    end else if (!calm && $urandom_range(0, 9) < 2) begin
      cmd.ready <= 1'b0;
      stall <= ($urandom_range(0, 9) < 8) ? $urandom_range(0, 2) : $urandom_range(10, 40);
    end else begin
      cmd.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    script_row_t script[$];
    script_row_t r;
    logic [31:0] lo_pick;
    logic [31:0] hi_pick;
    int          count;

    cfg_write = 1'b0;
    cfg_index = REG_REGION_START;
    cfg_data = 32'd0;
    rec.valid = 1'b0;
    rec.record_length = 10'd0;

    script.push_back(row_reject(10'd0, KIND_OVERSIZE));
    script.push_back(row_reject(10'd1023, KIND_OVERSIZE));
    script.push_back(row_cfg(REG_LOG_DISABLED, 32'd1));
    script.push_back(row_reject(10'd5, KIND_DISABLED));
    script.push_back(row_reject(10'd0, KIND_DISABLED));
    script.push_back(row_cfg(REG_LOG_DISABLED, 32'd0));
    r = row_item(10'd1);
    r.ngold = 2'd3;
    r.gold[0] = make_cmd(KIND_ERASE, 32'd0, '0, '0, '0, 1'b0);
    r.gold[1] = make_cmd(KIND_HEADER, 32'd0, '0, 8'd1, 11'(HEADER_BYTES), 1'b0);
    r.gold[2] = make_cmd(KIND_RECORD, 32'(HEADER_BYTES), 11'd1, '0, '0, 1'b1);
    script.push_back(r);
    script.push_back(row_item(10'd1019));
    script.push_back(row_item(10'd1020));
    script.push_back(row_reject(10'd1021, KIND_OVERSIZE));
    script.push_back(row_item(10'd600));
    script.push_back(row_item(10'd600));
    repeat (6) script.push_back(row_item(10'd1020));
    script.push_back(row_item(10'd512));
    // top page of the address space, whose next page wraps back to itself
    script.push_back(row_cfg(REG_REGION_START, 32'hFFFF_FFFF));
    script.push_back(row_cfg(REG_REGION_END, 32'd0));
    repeat (3) script.push_back(row_item(10'd1020));
    script.push_back(row_item(10'd4));

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (script[i]) begin
      if (script[i].is_cfg) write_reg(script[i].idx, script[i].value);
      else send_record(script[i]);
    end

    for (int p = 0; p < 6; p++) begin
      case (p % 4)
        0: begin
          lo_pick = 32'(PAGE_BYTES * $urandom_range(0, 8));
          hi_pick = lo_pick + 32'(PAGE_BYTES * $urandom_range(1, 6));
          lo_pick = lo_pick | 32'($urandom_range(0, PAGE_BYTES - 1));
          hi_pick = hi_pick | 32'($urandom_range(0, PAGE_BYTES - 1));
        end
        1: begin
          hi_pick = 32'(PAGE_BYTES * $urandom_range(0, 4)) | 32'($urandom_range(0, 1023));
          lo_pick = 32'(PAGE_BYTES * $urandom_range(5, 9)) | 32'($urandom_range(0, 1023));
        end
        2: begin
          lo_pick = 32'hFFFF_F000 | 32'($urandom_range(0, PAGE_BYTES - 1));
          hi_pick = ($urandom_range(0, 1) == 0) ? 32'hFFFF_FFFF : 32'($urandom_range(0, 1023));
        end
        default: begin
          lo_pick = $urandom;
          hi_pick = $urandom;
        end
      endcase
      calm = (p == 2);
      write_reg(REG_REGION_START, lo_pick);
      write_reg(REG_REGION_END, hi_pick);
      write_reg(REG_LOG_DISABLED, (p == 4) ? 32'd1 : 32'd0);
      count = (p == 4) ? 10 : 40;
      repeat (count) send_record(row_item(random_len()));
    end

    rec.valid <= 1'b0;
    calm = 1'b0;
    while (expected_cmds.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

>>> circular_flash_log_writer_core.f
+incdir+hdl
hdl/cflw_pkg.sv
hdl/cflw_rec_if.sv
hdl/cflw_cmd_if.sv
hdl/cflw_planner.sv
hdl/cflw_emitter.sv
hdl/circular_flash_log_writer_core.sv
dv/testbench.sv
